>>> hdl/signal_broadcast_task_table_core_defines.svh
// Assertion macros shared by the checker of the task table core.
// Needs clk and rst in the scope where a macro is used.
`ifndef SIGNAL_BROADCAST_TASK_TABLE_CORE_DEFINES_SVH
`define SIGNAL_BROADCAST_TASK_TABLE_CORE_DEFINES_SVH

// cond seen at one edge implies check at the next edge
`define SBTT_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

// cond implies check at the same edge
`define SBTT_ASSERT_SAME(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

`endif

>>> hdl/sbtt_pkg.sv
// Shared constants and types of the signal broadcast task table core.
// No dependencies; used by sbtt_ctrl, sbtt_dp and the top level.
package sbtt_pkg;

  localparam int NUM_SLOTS_DEF = 64;

  // request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_KILL  = 2'd2;

  localparam logic [5:0]  SIG_MAX   = 6'd32;
  localparam logic [5:0]  COUNT_MAX = 6'd63;
  localparam logic [15:0] SEL_ALL   = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture the incoming request
    logic wr;         // write the slot
    logic rd_cap;     // capture read data into the result
    logic scan_init;  // start a kill scan at slot 1
    logic scan_on;    // scan one slot this cycle
    logic load;       // move result into the output register
  } sbtt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kill_bad;   // signal number outside 1..32
    logic scan_last;  // last slot is being read
    logic out_free;   // output register can take a result
  } sbtt_sts_t;

endpackage

>>> hdl/sbtt_ctrl.sv
// Request sequencer of the task table core.
// Depends on sbtt_pkg; drives sbtt_dp through command and status structs.
module sbtt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            req_type,
  input  sbtt_pkg::sbtt_sts_t   sts,
  output sbtt_pkg::sbtt_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR    = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_RDC   = 3'd3;
  localparam logic [2:0] S_KCHK  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.latch = 1'b1;
          case (req_type)
            sbtt_pkg::REQ_WRITE: state_next = S_WR;
            sbtt_pkg::REQ_READ:  state_next = S_RD;
            sbtt_pkg::REQ_KILL:  state_next = S_KCHK;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_WR: begin
        cmd.wr = 1'b1;
        state_next = S_DONE;
      end
      S_RD: state_next = S_RDC;
      S_RDC: begin
        cmd.rd_cap = 1'b1;
        state_next = S_DONE;
      end
      S_KCHK: begin
        cmd.scan_init = 1'b1;
        state_next = sts.kill_bad ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_on = 1'b1;
        if (sts.scan_last) state_next = S_DRAIN;
      end
      // last slot's data is checked here
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/sbtt_dp.sv
// Datapath of the task table core: request register, task memories, kill
// match logic, delivery counter and output register. Depends on sbtt_pkg.
module sbtt_dp #(
  parameter int NUM_SLOTS = sbtt_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sbtt_pkg::sbtt_cmd_t cmd,
  output sbtt_pkg::sbtt_sts_t sts,
  input  logic                m_tready,
  output logic                out_valid,
  input  logic [1:0]          req_type,
  input  logic [5:0]          slot,
  input  logic                entry_valid,
  input  logic [15:0]         pid_value,
  input  logic [14:0]         group_value,
  input  logic [15:0]         uid_value,
  input  logic [15:0]         euid_value,
  input  logic [5:0]          sig_num,
  input  logic [14:0]         caller_pid,
  input  logic                privileged,
  output logic [31:0]         pending_mask,
  output logic                slot_valid_out,
  output logic [5:0]          delivered_count,
  output logic                bad_signal
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IW = 62;  // pid 15, group 15, uid 16, euid 16

  // latched request
  logic [1:0]  r_type;
  logic [5:0]  r_slot;
  logic        r_valid;
  logic [15:0] r_pid;
  logic [14:0] r_group;
  logic [15:0] r_uid;
  logic [15:0] r_euid;
  logic [5:0]  r_sig;
  logic [14:0] r_caller;
  logic        r_priv;

  logic [IW-1:0] info_mem [NUM_SLOTS];
  logic [31:0]   mask_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_bits;
  logic [NUM_SLOTS-1:0] written;   // mask reads as zero until first write

  logic [IW-1:0] rd_info_q;
  logic [31:0]   rd_mask_q;
  logic [AW-1:0] rd_idx_q;
  logic          rd_live_q;

  logic [AW-1:0] scan_idx;
  logic [5:0]    count;
  logic [31:0]   res_mask;
  logic          res_valid;

  logic [AW-1:0] slot_idx;
  logic          in_range;
  logic [AW-1:0] rd_addr;
  logic          kill_bad;
  logic [4:0]    sig_shamt;
  logic [31:0]   sig_bit;
  logic [15:0]   neg_sel;
  logic [14:0]   t_pid;
  logic [14:0]   t_group;
  logic [15:0]   t_uid;
  logic [15:0]   t_euid;
  logic          selected;
  logic          allowed;
  logic          deliver;
  logic          mask_we;
  logic [AW-1:0] mask_waddr;
  logic [31:0]   mask_wdata;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_type   <= req_type;
      r_slot   <= slot;
      r_valid  <= entry_valid;
      r_pid    <= pid_value;
      r_group  <= group_value;
      r_uid    <= uid_value;
      r_euid   <= euid_value;
      r_sig    <= sig_num;
      r_caller <= caller_pid;
      r_priv   <= privileged;
    end
  end

  assign slot_idx  = AW'(r_slot);
  assign in_range  = 32'(r_slot) < NUM_SLOTS;
  assign rd_addr   = cmd.scan_on ? scan_idx : slot_idx;
  assign kill_bad  = (r_sig == 6'd0) || (r_sig > sbtt_pkg::SIG_MAX);
  assign sig_shamt = 5'(r_sig - 6'd1);
  assign sig_bit   = 32'd1 << sig_shamt;
  assign neg_sel   = 16'd0 - r_pid;

  assign t_pid   = rd_info_q[61:47];
  assign t_group = rd_info_q[46:32];
  assign t_uid   = rd_info_q[31:16];
  assign t_euid  = rd_info_q[15:0];

  always_comb begin
    if (r_pid == 16'd0) begin
      selected = (t_group == r_caller);
    end else if (!r_pid[15]) begin
      selected = (t_pid == r_pid[14:0]);
    end else if (r_pid == sbtt_pkg::SEL_ALL) begin
      selected = 1'b1;
    end else begin
      // negated group; -32768 has no 15-bit match
      selected = ({1'b0, t_group} == neg_sel);
    end
  end

  assign allowed = r_priv || (r_uid == t_uid) || (r_euid == t_uid) ||
                   (r_uid == t_euid) || (r_euid == t_euid);
  assign deliver = rd_live_q && valid_bits[rd_idx_q] && selected && allowed;

  assign mask_we    = (cmd.wr && in_range) || deliver;
  assign mask_waddr = deliver ? rd_idx_q : slot_idx;
  assign mask_wdata = deliver ? (rd_mask_q | sig_bit) : 32'd0;

  // task memories
  always_ff @(posedge clk) begin
    if (cmd.wr && in_range) begin
      info_mem[slot_idx] <= {r_pid[14:0], r_group, r_uid, r_euid};
    end
    rd_info_q <= info_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    rd_mask_q <= mask_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      written    <= '0;
    end else if (cmd.wr && in_range) begin
      valid_bits[slot_idx] <= r_valid;
      written[slot_idx]    <= 1'b1;
    end
  end

  // scan pipeline: address this cycle, check and write back the next
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live_q <= 1'b0;
    end else begin
      rd_live_q <= cmd.scan_on;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= scan_idx;
    if (cmd.scan_init) begin
      scan_idx <= AW'(1);
    end else if (cmd.scan_on) begin
      scan_idx <= scan_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      count     <= '0;
      res_mask  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (deliver && (count != sbtt_pkg::COUNT_MAX)) begin
        count <= count + 6'd1;
      end
      if (cmd.rd_cap) begin
        res_mask  <= (in_range && written[slot_idx]) ? rd_mask_q : 32'd0;
        res_valid <= in_range && valid_bits[slot_idx];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.load || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pending_mask    <= res_mask;
      slot_valid_out  <= res_valid;
      delivered_count <= count;
      bad_signal      <= (r_type == sbtt_pkg::REQ_KILL) && kill_bad;
    end
  end

  assign sts.kill_bad  = kill_bad;
  assign sts.scan_last = (scan_idx == AW'(NUM_SLOTS - 1));
  assign sts.out_free  = !out_valid || m_tready;

endmodule

>>> hdl/signal_broadcast_task_table_core.sv
// Task table with signal delivery. A write fills a slot and clears its pending
// mask; a read returns a slot's mask and valid bit; a kill walks slots 1 and up
// and sets the signal bit in every valid, matching, permitted slot, returning
// how many (saturating at 63). One request is worked on at a time and each
// request gives exactly one result. A kill scan reads and writes back one slot
// per cycle through the single port pair of the pending-mask memory; a kill with
// a bad signal number skips the scan. The output register lets the next request
// be accepted while a result waits. No clearing pass after reset: valid and
// written flags are flip-flops cleared by rst.
module signal_broadcast_task_table_core #(
  parameter int NUM_SLOTS = sbtt_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [5:0] slot, [6] entry_valid, [22:7] pid_value, [37:23] group_value,
  // [53:38] uid_value, [69:54] euid_value, [75:70] sig_num,
  // [90:76] caller_pid, [91] privileged, [95:92] zero
  input  logic [95:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] pending_mask, [32] slot_valid_out, [38:33] delivered_count,
  // [39] bad_signal
  output logic [39:0] m_tdata
);

  sbtt_pkg::sbtt_cmd_t cmd;
  sbtt_pkg::sbtt_sts_t sts;

  logic [31:0] pending_mask;
  logic        slot_valid_out;
  logic [5:0]  delivered_count;
  logic        bad_signal;

  sbtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbtt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .m_tready        (m_tready),
    .out_valid       (m_tvalid),
    .req_type        (s_tuser),
    .slot            (s_tdata[5:0]),
    .entry_valid     (s_tdata[6]),
    .pid_value       (s_tdata[22:7]),
    .group_value     (s_tdata[37:23]),
    .uid_value       (s_tdata[53:38]),
    .euid_value      (s_tdata[69:54]),
    .sig_num         (s_tdata[75:70]),
    .caller_pid      (s_tdata[90:76]),
    .privileged      (s_tdata[91]),
    .pending_mask    (pending_mask),
    .slot_valid_out  (slot_valid_out),
    .delivered_count (delivered_count),
    .bad_signal      (bad_signal)
  );

  assign m_tdata = {bad_signal, delivered_count, slot_valid_out, pending_mask};

endmodule

>>> hdl/sbtt_chk.sv
// Port-level checker for the task table core, bound to the top level.
// Uses the assertion macros of signal_broadcast_task_table_core_defines.svh.
`include "signal_broadcast_task_table_core_defines.svh"

module sbtt_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  `SBTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
  `SBTT_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken while one is in progress")
  `SBTT_ASSERT_SAME(a_bad_clean, m_tvalid && m_tdata[39], m_tdata[38:0] == 39'd0, "bad signal result carries data")
  `SBTT_ASSERT_SAME(a_no_early, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result appeared right after a request")

endmodule

bind signal_broadcast_task_table_core sbtt_chk u_sbtt_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/signal_broadcast_task_table_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for signal_broadcast_task_table_core: writes, reads and kills
// go through the stream ports; each result is checked against a task table model
// or a fixed expectation. Depends on sbtt_pkg and the core.
module signal_broadcast_task_table_core_tb;

  localparam int SLOTS = sbtt_pkg::NUM_SLOTS_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = SLOTS + 40;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic        entry_valid;
    logic [15:0] pid;
    logic [14:0] group;
    logic [15:0] uid;
    logic [15:0] euid;
    logic [5:0]  sig;
    logic [14:0] caller;
    logic        priv;
  } sig_req_t;

  // same layout as m_tdata
  typedef struct packed {
    logic        bad;
    logic [5:0]  count;
    logic        valid;
    logic [31:0] mask;
  } sig_res_t;

  typedef struct {
    sig_req_t req;
    bit       typed;
    sig_res_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  // task table copy
  logic        tbl_valid [SLOTS];
  logic [14:0] tbl_pid   [SLOTS];
  logic [14:0] tbl_group [SLOTS];
  logic [15:0] tbl_uid   [SLOTS];
  logic [15:0] tbl_euid  [SLOTS];
  logic [31:0] tbl_pend  [SLOTS];

  sig_res_t  awaited_results[$];
  stim_row_t directed_rows[$];
  int        err_count;
  int        tx_idle_pct;
  int        rx_stall_pct;

  signal_broadcast_task_table_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic sig_req_t mk_req(logic [1:0] kind, logic [5:0] slot, logic v,
                                      logic [15:0] pid, logic [14:0] group,
                                      logic [15:0] uid, logic [15:0] euid,
                                      logic [5:0] sig, logic [14:0] caller, logic priv);
    sig_req_t r;
    r.kind = kind; r.slot = slot; r.entry_valid = v; r.pid = pid; r.group = group;
    r.uid = uid; r.euid = euid; r.sig = sig; r.caller = caller; r.priv = priv;
    return r;
  endfunction

  function automatic sig_res_t mk_res(logic [31:0] mask, logic valid, logic [5:0] count,
                                      logic bad);
    sig_res_t o;
    o.mask = mask; o.valid = valid; o.count = count; o.bad = bad;
    return o;
  endfunction

  // Applies one request to the table copy and returns the result it yields.
  function automatic sig_res_t predict_delivery(sig_req_t r);
    sig_res_t    o;
    logic [31:0] sig_bit;
    int          hits;
    bit          sel_ok;
    bit          perm_ok;
    o = '0;
    case (r.kind)
      sbtt_pkg::REQ_WRITE: begin
        tbl_valid[r.slot] = r.entry_valid;
        tbl_pid[r.slot]   = r.pid[14:0];
        tbl_group[r.slot] = r.group;
        tbl_uid[r.slot]   = r.uid;
        tbl_euid[r.slot]  = r.euid;
        tbl_pend[r.slot]  = '0;
      end
      sbtt_pkg::REQ_READ: begin
        o.mask  = tbl_pend[r.slot];
        o.valid = tbl_valid[r.slot];
      end
      sbtt_pkg::REQ_KILL: begin
        if (r.sig == 6'd0 || r.sig > sbtt_pkg::SIG_MAX) begin
          o.bad = 1'b1;
        end else begin
          sig_bit = 32'd1 << (r.sig - 6'd1);
          hits = 0;
          // slot 0 never gets signals
          for (int s = 1; s < SLOTS; s++) begin
            if (!tbl_valid[s]) continue;
            if (r.pid == 16'd0)
              sel_ok = (tbl_group[s] == r.caller);
            else if (!r.pid[15])
              sel_ok = (tbl_pid[s] == r.pid[14:0]);
            else if (r.pid == sbtt_pkg::SEL_ALL)
              sel_ok = 1'b1;
            else
              sel_ok = (int'(tbl_group[s]) == 65536 - int'(r.pid));
            perm_ok = r.priv || r.uid == tbl_uid[s] || r.euid == tbl_uid[s] ||
                      r.uid == tbl_euid[s] || r.euid == tbl_euid[s];
            if (sel_ok && perm_ok) begin
              tbl_pend[s] |= sig_bit;
              if (hits < sbtt_pkg::COUNT_MAX) hits++;
            end
          end
          o.count = 6'(hits);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Mostly small value pools so kills find targets; the rest is full range.
  function automatic sig_req_t rand_req();
    sig_req_t r;
    int       pick;
    logic [14:0] grp;
    pick = $urandom_range(99);
    r.kind = (pick < 35) ? sbtt_pkg::REQ_WRITE : (pick < 60) ? sbtt_pkg::REQ_READ :
             (pick < 95) ? sbtt_pkg::REQ_KILL : REQ_UNUSED;
    r.slot = 6'($urandom_range(SLOTS - 1));
    r.entry_valid = ($urandom_range(99) < 85);
    grp = ($urandom_range(3) != 0) ? 15'($urandom_range(1, 4)) : 15'($urandom);
    r.group = grp;
    r.uid  = ($urandom_range(3) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    r.euid = ($urandom_range(3) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    r.caller = ($urandom_range(9) < 7) ? grp : 15'($urandom);
    r.sig  = ($urandom_range(99) < 85) ? 6'($urandom_range(1, 32)) : 6'($urandom);
    r.priv = ($urandom_range(99) < 40);
    if (r.kind == sbtt_pkg::REQ_KILL) begin
      case ($urandom_range(4))
        0: r.pid = 16'd0;
        1: r.pid = 16'($urandom_range(1, 6));
        2: r.pid = sbtt_pkg::SEL_ALL;
        3: r.pid = 16'(-int'(grp));
        default: r.pid = 16'($urandom);
      endcase
    end else begin
      r.pid = ($urandom_range(3) != 0) ? 16'($urandom_range(1, 6)) : 16'($urandom);
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic add_row(sig_req_t r, bit typed, sig_res_t want);
    stim_row_t row;
    row.req = r; row.typed = typed; row.want = want;
    directed_rows.push_back(row);
  endtask

  // present one request; the expectation is queued at the accepting edge
  task automatic send_req(sig_req_t r, bit typed, sig_res_t want);
    sig_res_t pred;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {4'd0, r.priv, r.caller, r.sig, r.euid, r.uid, r.group, r.pid,
                 r.entry_valid, r.slot};
    do @(posedge clk); while (!s_tready);
    pred = predict_delivery(r);
    awaited_results.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    sig_res_t got;
    sig_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected result", got[31:0], 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (got.mask != want.mask) flag_mismatch("pending_mask", got.mask, want.mask);
        if (got.valid != want.valid)
          flag_mismatch("slot_valid_out", 32'(got.valid), 32'(want.valid));
        if (got.count != want.count)
          flag_mismatch("delivered_count", 32'(got.count), 32'(want.count));
        if (got.bad != want.bad)
          flag_mismatch("bad_signal", 32'(got.bad), 32'(want.bad));
      end
    end
  end

  initial begin
    sig_res_t zero_res;
    sig_req_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = sbtt_pkg::REQ_WRITE;
    err_count = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    zero_res = '0;
    for (int s = 0; s < SLOTS; s++) begin
      tbl_valid[s] = 1'b0; tbl_pid[s] = '0; tbl_group[s] = '0;
      tbl_uid[s] = '0; tbl_euid[s] = '0; tbl_pend[s] = '0;
    end

    // empty table, bad signal numbers, unknown kind
    add_row(mk_req(sbtt_pkg::REQ_READ, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_READ, 6'd63, 1, '1, '1, '1, '1, '1, '1, 1), 1, zero_res);
    add_row(mk_req(REQ_UNUSED, 6'd63, 1, '1, '1, '1, '1, 6'd5, '1, 1), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_KILL, 6'd0, 0, sbtt_pkg::SEL_ALL, 0, 0, 0, 6'd0, 0, 1), 1,
            mk_res(0, 0, 0, 1));
    add_row(mk_req(sbtt_pkg::REQ_KILL, 6'd0, 0, sbtt_pkg::SEL_ALL, 0, 0, 0, 6'd33, 0, 1), 1,
            mk_res(0, 0, 0, 1));
    add_row(mk_req(sbtt_pkg::REQ_KILL, 6'd0, 0, sbtt_pkg::SEL_ALL, 0, 0, 0, 6'd63, 0, 1), 1,
            mk_res(0, 0, 0, 1));
    add_row(mk_req(sbtt_pkg::REQ_KILL, 6'd0, 0, sbtt_pkg::SEL_ALL, 0, 0, 0, 6'd1, 0, 1), 1,
            zero_res);
    // fill a few slots, extremes included
    add_row(mk_req(sbtt_pkg::REQ_WRITE, 6'd1, 1, 16'd100, 15'd7, 16'd1000, 16'd2000,
                   0, 0, 0), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_WRITE, 6'd63, 1, 16'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF,
                   0, 0, 0), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_WRITE, 6'd0, 1, 16'd100, 15'd7, 16'd1000, 16'd2000,
                   0, 0, 0), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_WRITE, 6'd2, 0, 16'd100, 15'd7, 16'd1000, 16'd2000,
                   0, 0, 0), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_WRITE, 6'd3, 1, 16'hFFFB, 15'd5, 16'd3, 16'd4, 0, 0, 0), 1,
            zero_res);
    // pid target, then same signal again while pending
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, 16'd100, 0, 16'd1000, 16'd9, 6'd32, 0, 0), 0,
            zero_res);
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, 16'd100, 0, 16'd1000, 16'd9, 6'd32, 0, 0), 0,
            zero_res);
    add_row(mk_req(sbtt_pkg::REQ_READ, 6'd1, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    // caller's own group, permitted through euid
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, 16'd0, 0, 16'd9, 16'd2000, 6'd5, 15'd7, 0), 0,
            zero_res);
    // group target without permission
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, 16'hFFF9, 0, 16'd0, 16'd0, 6'd1, 0, 0), 0,
            zero_res);
    // most negative selector hits nobody
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, 16'h8000, 0, 0, 0, 6'd2, 0, 1), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, sbtt_pkg::SEL_ALL, 0, 0, 0, 6'd3, 0, 1), 0,
            zero_res);
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, 16'h7FFF, 0, 16'hFFFF, 0, 6'd4, 0, 0), 0,
            zero_res);
    add_row(mk_req(sbtt_pkg::REQ_KILL, 0, 0, 16'hFFFB, 0, 16'd4, 16'd8, 6'd6, 0, 0), 0,
            zero_res);
    add_row(mk_req(sbtt_pkg::REQ_READ, 6'd3, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_READ, 6'd63, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_READ, 6'd0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_WRITE, 6'd1, 0, 16'd100, 15'd7, 16'd1000, 16'd2000,
                   0, 0, 0), 1, zero_res);
    add_row(mk_req(sbtt_pkg::REQ_READ, 6'd1, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero_res);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct  = (ph == 0) ? 33 : (ph == 1) ? 80 : 0;
      rx_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 33 : 0;
      if (ph == 2) begin
        // populate the whole table, then a broadcast kill for a big count
        for (int s = 0; s < SLOTS; s++) begin
          r = rand_req();
          r.kind = sbtt_pkg::REQ_WRITE;
          r.slot = 6'(s);
          r.entry_valid = 1'b1;
          send_req(r, 0, zero_res);
        end
        r = rand_req();
        r.kind = sbtt_pkg::REQ_KILL;
        r.pid = sbtt_pkg::SEL_ALL;
        r.priv = 1'b1;
        r.sig = 6'($urandom_range(1, 32));
        send_req(r, 0, zero_res);
      end
      for (int n = 0; n < 110; n++) send_req(rand_req(), 0, zero_res);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
